// ===== src/scancode_to_char_fifo_unit_assert.svh =====
// Assertion macros for the scancode decoder with character FIFO
`ifndef SCANCODE_TO_CHAR_FIFO_UNIT_ASSERT_SVH
`define SCANCODE_TO_CHAR_FIFO_UNIT_ASSERT_SVH

// same-cycle implication
`define SC2CH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SC2CH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sc2ch_pkg.sv =====
// Package: scancode constants, key tables and command type
`default_nettype none

package sc2ch_pkg;

	localparam int FIFO_DEPTH_DEF = 128;
	localparam int CMDQ_DEPTH     = 4;
	localparam int CMDQ_AW        = $clog2(CMDQ_DEPTH);

	localparam logic [7:0] BASE_RST = 8'd128;

	// scancodes, set 1
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_CTRL       = 8'h1D;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
	localparam logic [7:0] SC_CAPS       = 8'h3A;
	localparam logic [7:0] SC_PGUP       = 8'h49;
	localparam logic [7:0] SC_PGDN       = 8'h51;
	localparam logic [7:0] SC_UP         = 8'h48;
	localparam logic [7:0] SC_DOWN       = 8'h50;
	localparam logic [7:0] SC_F1         = 8'h3B;
	localparam logic [7:0] SC_F5         = 8'h3F;
	localparam logic [7:0] SC_KEY_S      = 8'h1F;

	// offsets from the special code base
	localparam logic [7:0] SP_PGUP  = 8'd0;
	localparam logic [7:0] SP_PGDN  = 8'd1;
	localparam logic [7:0] SP_UP    = 8'd2;
	localparam logic [7:0] SP_DOWN  = 8'd3;
	localparam logic [7:0] SP_F1    = 8'd4;
	localparam logic [7:0] SP_CTRLS = 8'd9;

	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_CASE    = 8'h20;

	typedef struct packed {
		logic       is_read;
		logic [7:0] code;
	} cmd_t;

	function automatic logic [7:0] plain_map(input logic [6:0] idx);
		logic [7:0] c;
		case (idx)
			7'd1:  c = 8'h1B; 7'd2:  c = 8'h31; 7'd3:  c = 8'h32; 7'd4:  c = 8'h33;
			7'd5:  c = 8'h34; 7'd6:  c = 8'h35; 7'd7:  c = 8'h36; 7'd8:  c = 8'h37;
			7'd9:  c = 8'h38; 7'd10: c = 8'h39; 7'd11: c = 8'h30; 7'd12: c = 8'h2D;
			7'd13: c = 8'h3D; 7'd14: c = 8'h08; 7'd15: c = 8'h09; 7'd16: c = 8'h71;
			7'd17: c = 8'h77; 7'd18: c = 8'h65; 7'd19: c = 8'h72; 7'd20: c = 8'h74;
			7'd21: c = 8'h79; 7'd22: c = 8'h75; 7'd23: c = 8'h69; 7'd24: c = 8'h6F;
			7'd25: c = 8'h70; 7'd26: c = 8'h5B; 7'd27: c = 8'h5D; 7'd28: c = 8'h0A;
			7'd30: c = 8'h61; 7'd31: c = 8'h73; 7'd32: c = 8'h64; 7'd33: c = 8'h66;
			7'd34: c = 8'h67; 7'd35: c = 8'h68; 7'd36: c = 8'h6A; 7'd37: c = 8'h6B;
			7'd38: c = 8'h6C; 7'd39: c = 8'h3B; 7'd40: c = 8'h27; 7'd41: c = 8'h60;
			7'd43: c = 8'h5C; 7'd44: c = 8'h7A; 7'd45: c = 8'h78; 7'd46: c = 8'h63;
			7'd47: c = 8'h76; 7'd48: c = 8'h62; 7'd49: c = 8'h6E; 7'd50: c = 8'h6D;
			7'd51: c = 8'h2C; 7'd52: c = 8'h2E; 7'd53: c = 8'h2F; 7'd55: c = 8'h2A;
			7'd57: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] shifted_map(input logic [6:0] idx);
		logic [7:0] c;
		case (idx)
			7'd1:  c = 8'h1B; 7'd2:  c = 8'h21; 7'd3:  c = 8'h40; 7'd4:  c = 8'h23;
			7'd5:  c = 8'h24; 7'd6:  c = 8'h25; 7'd7:  c = 8'h5E; 7'd8:  c = 8'h26;
			7'd9:  c = 8'h2A; 7'd10: c = 8'h28; 7'd11: c = 8'h29; 7'd12: c = 8'h5F;
			7'd13: c = 8'h2B; 7'd14: c = 8'h08; 7'd15: c = 8'h09; 7'd16: c = 8'h51;
			7'd17: c = 8'h57; 7'd18: c = 8'h45; 7'd19: c = 8'h52; 7'd20: c = 8'h54;
			7'd21: c = 8'h59; 7'd22: c = 8'h55; 7'd23: c = 8'h49; 7'd24: c = 8'h4F;
			7'd25: c = 8'h50; 7'd26: c = 8'h7B; 7'd27: c = 8'h7D; 7'd28: c = 8'h0A;
			7'd30: c = 8'h41; 7'd31: c = 8'h53; 7'd32: c = 8'h44; 7'd33: c = 8'h46;
			7'd34: c = 8'h47; 7'd35: c = 8'h48; 7'd36: c = 8'h4A; 7'd37: c = 8'h4B;
			7'd38: c = 8'h4C; 7'd39: c = 8'h3A; 7'd40: c = 8'h22; 7'd41: c = 8'h7E;
			7'd43: c = 8'h7C; 7'd44: c = 8'h5A; 7'd45: c = 8'h58; 7'd46: c = 8'h43;
			7'd47: c = 8'h56; 7'd48: c = 8'h42; 7'd49: c = 8'h4E; 7'd50: c = 8'h4D;
			7'd51: c = 8'h3C; 7'd52: c = 8'h3E; 7'd53: c = 8'h3F; 7'd55: c = 8'h2A;
			7'd57: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/sc2ch_ifs.sv =====
// Request and response channel interfaces
`default_nettype none

interface sc2ch_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] scan_byte;

	modport source (output valid, req_type, scan_byte, input ready);
	modport sink   (input valid, req_type, scan_byte, output ready);
endinterface

interface sc2ch_rsp_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [7:0] char_code;

	modport source (output valid, char_valid, char_code, input ready);
	modport sink   (input valid, char_valid, char_code, output ready);
endinterface

`default_nettype wire

// ===== src/sc2ch_front.sv =====
// Front end: takes request beats, tracks modifiers, turns keys into commands
`default_nettype none

module sc2ch_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	sc2ch_req_if.sink            req,
	input  wire logic [7:0]      base,
	input  wire logic            cmdq_full,
	output sc2ch_pkg::cmd_t      cmd,
	output logic                 cmd_push
);

	logic shift_q, ctrl_q, caps_q;
	logic shift_d, ctrl_d, caps_d;
	logic emit;
	logic [7:0] sc, ch, plain;
	logic accept;

	assign req.ready = !cmdq_full;
	assign accept    = req.valid && req.ready;
	assign sc        = req.scan_byte;
	assign plain     = sc2ch_pkg::plain_map(sc[6:0]);

	// ordinary key through the tables
	always_comb begin
		ch = plain;
		if (plain >= sc2ch_pkg::CH_LOWER_A && plain <= sc2ch_pkg::CH_LOWER_Z) begin
			if (caps_q != shift_q)
				ch = plain - sc2ch_pkg::CH_CASE;
		end else if (shift_q) begin
			ch = sc2ch_pkg::shifted_map(sc[6:0]);
		end
	end

	always_comb begin
		shift_d     = shift_q;
		ctrl_d      = ctrl_q;
		caps_d      = caps_q;
		emit        = 1'b0;
		cmd.is_read = req.req_type;
		cmd.code    = '0;
		if (req.req_type) begin
			emit = 1'b1;
		end else begin
			unique case (sc) inside
				sc2ch_pkg::SC_LSHIFT, sc2ch_pkg::SC_RSHIFT: shift_d = 1'b1;
				sc2ch_pkg::SC_LSHIFT_BRK, sc2ch_pkg::SC_RSHIFT_BRK: shift_d = 1'b0;
				sc2ch_pkg::SC_CTRL:     ctrl_d = 1'b1;
				sc2ch_pkg::SC_CTRL_BRK: ctrl_d = 1'b0;
				sc2ch_pkg::SC_CAPS:     caps_d = !caps_q;
				sc2ch_pkg::SC_PGUP: begin
					emit     = 1'b1;
					cmd.code = base + sc2ch_pkg::SP_PGUP;
				end
				sc2ch_pkg::SC_PGDN: begin
					emit     = 1'b1;
					cmd.code = base + sc2ch_pkg::SP_PGDN;
				end
				sc2ch_pkg::SC_UP: begin
					emit     = 1'b1;
					cmd.code = base + sc2ch_pkg::SP_UP;
				end
				sc2ch_pkg::SC_DOWN: begin
					emit     = 1'b1;
					cmd.code = base + sc2ch_pkg::SP_DOWN;
				end
				[sc2ch_pkg::SC_F1:sc2ch_pkg::SC_F5]: begin
					emit     = 1'b1;
					cmd.code = base + sc2ch_pkg::SP_F1 + (sc - sc2ch_pkg::SC_F1);
				end
				sc2ch_pkg::SC_KEY_S: begin
					emit     = ctrl_q || (ch != 8'h00);
					cmd.code = ctrl_q ? base + sc2ch_pkg::SP_CTRLS : ch;
				end
				default: begin
					// other break codes are ignored
					if (!sc[7]) begin
						emit     = (ch != 8'h00);
						cmd.code = ch;
					end
				end
			endcase
		end
	end

	assign cmd_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
			caps_q  <= 1'b0;
		end else if (accept) begin
			shift_q <= shift_d;
			ctrl_q  <= ctrl_d;
			caps_q  <= caps_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/sc2ch_cmdq.sv =====
// Short command queue between front end and character FIFO
`default_nettype none

module sc2ch_cmdq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sc2ch_pkg::cmd_t wdata,
	output logic                 full,
	output logic                 head_vld,
	output sc2ch_pkg::cmd_t      head,
	input  wire logic            pop
);

	sc2ch_pkg::cmd_t                   ent_q [sc2ch_pkg::CMDQ_DEPTH];
	logic [sc2ch_pkg::CMDQ_AW-1:0]     wr_q, rd_q;
	logic [sc2ch_pkg::CMDQ_AW:0]       cnt_q;

	assign full     = (cnt_q == (sc2ch_pkg::CMDQ_AW+1)'(sc2ch_pkg::CMDQ_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/sc2ch_back.sv =====
// Back end: character ring FIFO and registered read response
`default_nettype none

module sc2ch_back #(
	parameter int FIFO_DEPTH = sc2ch_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_vld,
	input  wire sc2ch_pkg::cmd_t cmd,
	output logic                 cmd_pop,
	sc2ch_rsp_if.source          rsp
);

	localparam int AW = $clog2(FIFO_DEPTH);

	logic [7:0]    mem [FIFO_DEPTH];
	logic [AW-1:0] wp_q, rp_q, wp_nxt, rp_nxt;
	logic [7:0]    rdata_q;
	logic          rsp_vld_q, cv_q;
	logic          out_free, empty, full, do_wr, do_rd;

	assign wp_nxt = (wp_q == AW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_nxt = (rp_q == AW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign empty  = (wp_q == rp_q);
	assign full   = (wp_nxt == rp_q);   // one slot kept free

	assign out_free = !rsp_vld_q || rsp.ready;
	// pushes never wait on the response side
	assign cmd_pop  = cmd_vld && (!cmd.is_read || out_free);
	assign do_wr    = cmd_pop && !cmd.is_read && !full;
	assign do_rd    = cmd_pop && cmd.is_read && !empty;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wp_q] <= cmd.code;
		if (do_rd)
			rdata_q <= mem[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			rsp_vld_q <= 1'b0;
			cv_q      <= 1'b0;
		end else begin
			if (do_wr)
				wp_q <= wp_nxt;
			if (do_rd)
				rp_q <= rp_nxt;
			if (cmd_pop && cmd.is_read) begin
				rsp_vld_q <= 1'b1;
				cv_q      <= !empty;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.char_valid = cv_q;
	assign rsp.char_code  = cv_q ? rdata_q : 8'h00;

endmodule

`default_nettype wire

// ===== src/scancode_to_char_fifo_unit.sv =====
// Top level: scancode set 1 decoder feeding a character ring FIFO
`default_nettype none

// Takes one request beat per cycle: a scancode byte (req_type 0) or a read
// (req_type 1). Scancodes update shift/ctrl/caps and may queue a character or
// a special key code (base from the config register, ten codes in a row); a
// read returns one response beat, char_valid 0 and code 0 when nothing is
// stored. A read response is presented once its command has passed through
// the four-entry command queue and the character store's registered read
// port; it waits in the queue while an earlier response is not yet taken.
// Input stalls only when the command queue fills, i.e. when read responses
// are not being taken. The store keeps FIFO_DEPTH-1 characters; a character
// arriving when it is full is dropped.
module scancode_to_char_fifo_unit #(
	parameter int FIFO_DEPTH = sc2ch_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sc2ch_req_if.sink       req,
	sc2ch_rsp_if.source     rsp,
	input  wire logic       wr_en,
	input  wire logic [7:0] wr_data
);

	logic [7:0]      base_q;
	sc2ch_pkg::cmd_t f_cmd, q_head;
	logic            f_push, q_full, q_vld, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			base_q <= sc2ch_pkg::BASE_RST;
		else if (wr_en)
			base_q <= wr_data;
	end

	sc2ch_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.base      (base_q),
		.cmdq_full (q_full),
		.cmd       (f_cmd),
		.cmd_push  (f_push)
	);

	sc2ch_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.wdata    (f_cmd),
		.full     (q_full),
		.head_vld (q_vld),
		.head     (q_head),
		.pop      (q_pop)
	);

	sc2ch_back #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_vld (q_vld),
		.cmd     (q_head),
		.cmd_pop (q_pop),
		.rsp     (rsp)
	);

`include "scancode_to_char_fifo_unit_assert.svh"

	`SC2CH_ASSERT_NOW(a_empty_code_zero, rsp.valid && !rsp.char_valid, rsp.char_code == 8'h00, "empty response carries a code")
	`SC2CH_ASSERT_NEXT(a_read_queued, req.valid && req.ready && req.req_type, q_vld, "read beat lost before command queue")
	`SC2CH_ASSERT_NEXT(a_read_taken, q_vld && q_head.is_read && !rsp.valid, rsp.valid, "queued read not served with free output")

endmodule

`default_nettype wire

// ===== verif/tb_scancode_to_char_fifo_unit.sv =====
// Testbench for the scancode decoder with character FIFO: random handshakes, self-checking
module tb_scancode_to_char_fifo_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sc2ch_pkg::*;

	typedef enum logic {REQ_SCAN = 1'b0, REQ_READ = 1'b1} req_kind_e;

	typedef struct packed {
		req_kind_e  kind;
		logic [7:0] scan;
	} key_beat_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_code;
	} char_beat_t;

	localparam int KEY_TBL_LEN = 60;
	localparam int STORE_SLOTS = FIFO_DEPTH_DEF - 1;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS = 10;
	localparam logic [7:0] BREAK_BIT = 8'h80;

	logic [7:0] plain_keys [KEY_TBL_LEN] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00
	};

	logic [7:0] shifted_keys [KEY_TBL_LEN] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       wr_en = 1'b0;
	logic [7:0] wr_data = 8'h00;

	logic       drv_valid = 1'b0;
	req_kind_e  drv_kind = REQ_SCAN;
	logic [7:0] drv_scan = 8'h00;
	logic       mon_ready = 1'b0;

	sc2ch_req_if req_ch ();
	sc2ch_rsp_if rsp_ch ();

	assign req_ch.valid     = drv_valid;
	assign req_ch.req_type  = drv_kind;
	assign req_ch.scan_byte = drv_scan;
	assign rsp_ch.ready     = mon_ready;

	scancode_to_char_fifo_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	// decoder state as the block should hold it
	logic       shift_pressed = 1'b0;
	logic       ctrl_pressed = 1'b0;
	logic       caps_on = 1'b0;
	logic [7:0] code_base = BASE_RST;
	logic [7:0] held_chars [$];

	key_beat_t  key_queue [$];
	char_beat_t char_expect [$];

	int n_queued = 0;
	int n_scans = 0;
	int n_reads = 0;
	int n_chars = 0;
	int n_empty = 0;
	int n_lost = 0;
	int n_bad = 0;

	int  gap_left = 0;
	int  stall_left = 0;
	int  send_run = 0;
	int  recv_run = 0;
	bit  send_steady = 1'b0;
	bit  recv_steady = 1'b0;
	key_beat_t  nxt_beat;
	char_beat_t want;
	logic [7:0] rand_base;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("scancode_to_char_fifo_unit: mismatch");
		$finish;
	end

	// alternates stretches of random waits with stretches of none
	function automatic int next_wait(inout int run_left, inout bit steady);
		if (run_left == 0) begin
			steady = ($urandom_range(0, 2) == 0);
			run_left = $urandom_range(8, 40);
		end
		run_left--;
		return steady ? 0 : int'($urandom_range(0, 3));
	endfunction

	function void store_char(input logic [7:0] code);
		if (held_chars.size() < STORE_SLOTS)
			held_chars.push_back(code);
		else
			n_lost++;
	endfunction

	function void apply_beat(input req_kind_e kind, input logic [7:0] sc);
		logic [7:0] ch;
		if (kind == REQ_READ) begin
			n_reads++;
			if (held_chars.size() == 0)
				char_expect.push_back('{1'b0, 8'h00});
			else
				char_expect.push_back('{1'b1, held_chars.pop_front()});
			return;
		end
		n_scans++;
		if (sc == SC_LSHIFT || sc == SC_RSHIFT)
			shift_pressed = 1'b1;
		else if (sc == SC_CTRL)
			ctrl_pressed = 1'b1;
		else if (sc == SC_LSHIFT_BRK || sc == SC_RSHIFT_BRK)
			shift_pressed = 1'b0;
		else if (sc == SC_CTRL_BRK)
			ctrl_pressed = 1'b0;
		else if (sc[7])
			;
		else if (sc == SC_CAPS)
			caps_on = !caps_on;
		else if (sc == SC_PGUP)
			store_char(code_base + SP_PGUP);
		else if (sc == SC_PGDN)
			store_char(code_base + SP_PGDN);
		else if (sc == SC_UP)
			store_char(code_base + SP_UP);
		else if (sc == SC_DOWN)
			store_char(code_base + SP_DOWN);
		else if (sc >= SC_F1 && sc <= SC_F5)
			store_char(code_base + SP_F1 + (sc - SC_F1));
		else if (ctrl_pressed && sc == SC_KEY_S)
			store_char(code_base + SP_CTRLS);
		else begin
			ch = (sc < KEY_TBL_LEN) ? plain_keys[sc] : 8'h00;
			if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
				if (caps_on != shift_pressed)
					ch = ch - CH_CASE;
			end else if (shift_pressed) begin
				ch = (sc < KEY_TBL_LEN) ? shifted_keys[sc] : 8'h00;
			end
			if (ch != 8'h00)
				store_char(ch);
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_kind <= REQ_SCAN;
			drv_scan <= 8'h00;
			gap_left = 0;
		end else begin
			if (drv_valid && req_ch.ready)
				apply_beat(drv_kind, drv_scan);
			if (!drv_valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					drv_valid <= 1'b0;
				end else if (key_queue.size() > 0) begin
					nxt_beat = key_queue.pop_front();
					drv_kind <= nxt_beat.kind;
					drv_scan <= nxt_beat.scan;
					drv_valid <= 1'b1;
					gap_left = next_wait(send_run, send_steady);
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mon_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && mon_ready) begin
				if (char_expect.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("unexpected char beat: valid %b code %02h",
							rsp_ch.char_valid, rsp_ch.char_code);
				end else begin
					want = char_expect.pop_front();
					if (want.char_valid) n_chars++; else n_empty++;
					if (rsp_ch.char_valid !== want.char_valid ||
							rsp_ch.char_code !== want.char_code) begin
						n_bad++;
						if (n_bad <= MAX_REPORTS)
							$display("char beat %0d: expected valid %b code %02h, got valid %b code %02h",
								n_chars + n_empty, want.char_valid, want.char_code,
								rsp_ch.char_valid, rsp_ch.char_code);
					end
				end
				stall_left = next_wait(recv_run, recv_steady);
			end
			if (stall_left > 0) begin
				stall_left--;
				mon_ready <= 1'b0;
			end else begin
				mon_ready <= 1'b1;
			end
		end
	end

	task automatic add_beat(input req_kind_e kind, input logic [7:0] sc);
		key_queue.push_back('{kind, sc});
		n_queued++;
	endtask

	// sender holds off until every read has answered, then lets scancodes still
	// in the command queue drain
	task automatic settle();
		while (key_queue.size() != 0 || drv_valid || char_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [7:0] value);
		settle();
		wr_en <= 1'b1;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		code_base = value;
	endtask

	// mostly well-formed key sequences with random content, some raw noise
	task automatic queue_typing(input int n_beats);
		int stop;
		int pick;
		logic [7:0] key;
		stop = n_queued + n_beats;
		while (n_queued < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				add_beat(REQ_READ, 8'($urandom_range(0, 255)));
			end else if (pick < 47) begin
				key = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
				add_beat(REQ_SCAN, key);
				repeat ($urandom_range(1, 4))
					add_beat(REQ_SCAN, 8'($urandom_range(1, KEY_TBL_LEN - 1)));
				add_beat(REQ_SCAN, key | BREAK_BIT);
			end else if (pick < 52) begin
				add_beat(REQ_SCAN, SC_CAPS);
				add_beat(REQ_SCAN, SC_CAPS | BREAK_BIT);
			end else if (pick < 58) begin
				add_beat(REQ_SCAN, SC_CTRL);
				if ($urandom_range(0, 1))
					add_beat(REQ_SCAN, SC_KEY_S);
				else
					add_beat(REQ_SCAN, 8'($urandom_range(1, KEY_TBL_LEN - 1)));
				add_beat(REQ_SCAN, SC_CTRL_BRK);
			end else if (pick < 66) begin
				case ($urandom_range(0, 4))
					0: key = SC_PGUP;
					1: key = SC_PGDN;
					2: key = SC_UP;
					3: key = SC_DOWN;
					default: key = SC_F1 + 8'($urandom_range(0, SC_F5 - SC_F1));
				endcase
				add_beat(REQ_SCAN, key);
				add_beat(REQ_SCAN, key | BREAK_BIT);
			end else if (pick < 88) begin
				key = 8'($urandom_range(1, KEY_TBL_LEN - 1));
				add_beat(REQ_SCAN, key);
				add_beat(REQ_SCAN, key | BREAK_BIT);
			end else begin
				add_beat(REQ_SCAN, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty read, out-of-table codes, case rules, ctrl, specials
		add_beat(REQ_READ, 8'hFF);
		add_beat(REQ_SCAN, 8'h00);
		add_beat(REQ_SCAN, 8'hFF);
		add_beat(REQ_SCAN, 8'h7F);
		add_beat(REQ_SCAN, 8'h1E);
		add_beat(REQ_SCAN, SC_LSHIFT);
		add_beat(REQ_SCAN, 8'h1E);
		add_beat(REQ_SCAN, 8'h02);
		add_beat(REQ_SCAN, SC_CAPS);
		add_beat(REQ_SCAN, 8'h1E);
		add_beat(REQ_SCAN, SC_LSHIFT_BRK);
		add_beat(REQ_SCAN, 8'h1E);
		add_beat(REQ_SCAN, 8'h02);
		add_beat(REQ_READ, 8'h00);
		add_beat(REQ_SCAN, SC_CAPS);
		add_beat(REQ_SCAN, SC_CTRL);
		add_beat(REQ_SCAN, SC_KEY_S);
		add_beat(REQ_SCAN, 8'h1E);
		add_beat(REQ_SCAN, SC_CTRL_BRK);
		add_beat(REQ_SCAN, SC_KEY_S);
		add_beat(REQ_SCAN, SC_PGUP);
		add_beat(REQ_SCAN, SC_PGDN);
		add_beat(REQ_SCAN, SC_UP);
		add_beat(REQ_SCAN, SC_DOWN);
		add_beat(REQ_SCAN, SC_F1);
		add_beat(REQ_SCAN, SC_F5);
		repeat (4) add_beat(REQ_READ, 8'($urandom_range(0, 255)));

		// lowest base; overfill the store, then read it dry
		write_base(8'd0);
		repeat (STORE_SLOTS + 8) add_beat(REQ_SCAN, 8'($urandom_range(8'h10, 8'h19)));
		repeat (STORE_SLOTS + 12) add_beat(REQ_READ, 8'($urandom_range(0, 255)));
		queue_typing(60);
		settle();
		queue_typing(60);

		write_base(8'd246);
		queue_typing(90);

		// special codes wrap past 255
		write_base(8'd255);
		queue_typing(90);

		rand_base = 8'($urandom_range(0, 246));
		write_base(rand_base);
		queue_typing(100);

		settle();
		$display("%0d scancodes and %0d reads sent; %0d characters and %0d empty reads returned",
			n_scans, n_reads, n_chars, n_empty);
		$display("%0d pushes lost to a full store; code bases 128, 0, 246, 255, %0d",
			n_lost, rand_base);
		if (n_bad == 0 && char_expect.size() == 0) begin
			$display("scancode_to_char_fifo_unit: match");
		end else begin
			$display("%0d bad char beats, %0d still expected", n_bad, char_expect.size());
			$display("scancode_to_char_fifo_unit: mismatch");
		end
		$finish;
	end

endmodule
